// ===== rtl/core/arphp_pkg.sv =====
// Shared types and constants for the ARP header parser.
// No dependencies; used by every module of the parser.
`timescale 1ns / 1ps
`default_nettype none

package arphp_pkg;

   localparam int HDR_LEN    = 28;
   localparam int HDR_IDX_W  = $clog2(HDR_LEN);
   localparam int COUNT_W    = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [15:0] HW_ETHERNET   = 16'd1;
   localparam logic [15:0] HW_IEEE802    = 16'd6;
   localparam logic [15:0] HW_FRAME_RLY  = 16'd15;
   localparam logic [15:0] HW_ATM        = 16'd16;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [15:0] PROTO_IPV6    = 16'h86DD;
   localparam logic [7:0]  ETH_HW_LEN    = 8'd6;
   localparam logic [7:0]  IPV4_PROTO_LEN = 8'd4;
   localparam logic [15:0] OPCODE_MIN    = 16'd1;
   localparam logic [15:0] OPCODE_MAX    = 16'd4;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_TOO_SHORT   = 2'd1,
      ST_BAD_FORMAT  = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0]        hw_type;
      logic [15:0]        proto_kind;
      logic [7:0]         hw_addr_len;
      logic [7:0]         proto_addr_len;
      logic [15:0]        op_code;
      logic [47:0]        src_mac;
      logic [31:0]        src_ip;
      logic [47:0]        dst_mac;
      logic [31:0]        dst_ip;
      logic [COUNT_W-1:0] total_bytes;
   } record_type;

endpackage

`default_nettype wire

// ===== rtl/core/arphp_front.sv =====
// Front end: takes packet bytes, captures the 28-byte header and counts bytes.
// Emits one header record per packet on the last byte. Depends on arphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arphp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 frame_end,
   output logic                      rec_push,
   output arphp_pkg::record_type     rec
);

   logic [7:0]                     hdr_ff [arphp_pkg::HDR_LEN];
   logic [7:0]                     hdr_in [arphp_pkg::HDR_LEN];
   logic [7:0]                     hdr_nx [arphp_pkg::HDR_LEN];
   logic [arphp_pkg::COUNT_W-1:0]  count_ff, count_in, count_nx;
   logic                           in_hdr;

   assign in_hdr = count_ff < arphp_pkg::COUNT_W'(arphp_pkg::HDR_LEN);

   always_comb begin
      for (int i = 0; i < arphp_pkg::HDR_LEN; i++) begin
         hdr_nx[i] = (accept && in_hdr &&
                      count_ff[arphp_pkg::HDR_IDX_W-1:0] == arphp_pkg::HDR_IDX_W'(i))
                     ? data_byte : hdr_ff[i];
      end
      count_nx = (accept && count_ff != arphp_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      // last byte hands the header off and starts the next packet from zero
      for (int i = 0; i < arphp_pkg::HDR_LEN; i++) begin
         hdr_in[i] = (accept && frame_end) ? 8'd0 : hdr_nx[i];
      end
      count_in = (accept && frame_end) ? '0 : count_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < arphp_pkg::HDR_LEN; i++) hdr_ff[i] <= 8'd0;
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < arphp_pkg::HDR_LEN; i++) hdr_ff[i] <= hdr_in[i];
      end
   end

   assign rec_push = accept && frame_end;

   always_comb begin
      rec.hw_type        = {hdr_nx[0], hdr_nx[1]};
      rec.proto_kind     = {hdr_nx[2], hdr_nx[3]};
      rec.hw_addr_len    = hdr_nx[4];
      rec.proto_addr_len = hdr_nx[5];
      rec.op_code        = {hdr_nx[6], hdr_nx[7]};
      rec.src_mac        = {hdr_nx[8], hdr_nx[9], hdr_nx[10], hdr_nx[11],
                            hdr_nx[12], hdr_nx[13]};
      rec.src_ip         = {hdr_nx[14], hdr_nx[15], hdr_nx[16], hdr_nx[17]};
      rec.dst_mac        = {hdr_nx[18], hdr_nx[19], hdr_nx[20], hdr_nx[21],
                            hdr_nx[22], hdr_nx[23]};
      rec.dst_ip         = {hdr_nx[24], hdr_nx[25], hdr_nx[26], hdr_nx[27]};
      rec.total_bytes    = count_nx;
   end

endmodule

`default_nettype wire

// ===== rtl/core/arphp_fifo.sv =====
// Two-entry queue of header records between front and back end.
// Depends on arphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arphp_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  arphp_pkg::record_type     push_rec,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output arphp_pkg::record_type     pop_rec
);

   arphp_pkg::record_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign valid   = cnt_ff != 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign pop_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/arphp_back.sv =====
// Back end: checks a header record, sets its status and holds the result
// in an output register until popped. Depends on arphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arphp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  arphp_pkg::record_type     q_rec,
   output logic                      q_pop,
   input  wire logic                 out_pop,
   output logic                      out_valid,
   output arphp_pkg::record_type     out_rec,
   output arphp_pkg::status_type     out_status
);

   logic                  valid_ff, valid_in;
   arphp_pkg::record_type rec_ff;
   arphp_pkg::status_type status_ff, status_in;
   logic                  too_short, bad_format, unsupported;
   logic                  hw_ok, proto_ok;

   always_comb begin
      too_short  = q_rec.total_bytes < arphp_pkg::COUNT_W'(arphp_pkg::HDR_LEN);
      bad_format = q_rec.hw_addr_len == 8'd0 || q_rec.proto_addr_len == 8'd0 ||
                   q_rec.op_code < arphp_pkg::OPCODE_MIN ||
                   q_rec.op_code > arphp_pkg::OPCODE_MAX ||
                   (q_rec.hw_type == arphp_pkg::HW_ETHERNET &&
                    q_rec.hw_addr_len != arphp_pkg::ETH_HW_LEN) ||
                   (q_rec.proto_kind == arphp_pkg::PROTO_IPV4 &&
                    q_rec.proto_addr_len != arphp_pkg::IPV4_PROTO_LEN);
      hw_ok      = q_rec.hw_type == arphp_pkg::HW_ETHERNET ||
                   q_rec.hw_type == arphp_pkg::HW_IEEE802 ||
                   q_rec.hw_type == arphp_pkg::HW_FRAME_RLY ||
                   q_rec.hw_type == arphp_pkg::HW_ATM;
      proto_ok   = q_rec.proto_kind == arphp_pkg::PROTO_IPV4 ||
                   q_rec.proto_kind == arphp_pkg::PROTO_IPV6;
      unsupported = !hw_ok || !proto_ok;
      priority if (too_short)   status_in = arphp_pkg::ST_TOO_SHORT;
      else if (bad_format)      status_in = arphp_pkg::ST_BAD_FORMAT;
      else if (unsupported)     status_in = arphp_pkg::ST_UNSUPPORTED;
      else                      status_in = arphp_pkg::ST_OK;
   end

   // refill the output register whenever it is empty or being drained
   assign q_pop    = q_valid && (!valid_ff || out_pop);
   assign valid_in = q_pop || (valid_ff && !out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff    <= q_rec;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_rec    = rec_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire

// ===== rtl/core/arp_header_parser_top.sv =====
// ARP header parser top level: front end, record queue and back end.
// Depends on arphp_pkg, arphp_front, arphp_fifo and arphp_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per cycle while req_full is low and, on the byte flagged
// frame_end, returns one result with the captured 28-byte header, the saturating
// byte count and a status. The record is queued on the last byte and checked as it
// enters the output register. Bytes flow as long as the two-entry record queue has
// room, so back-to-back one-byte packets keep going while results are popped;
// req_full rises only when the queue and the output register all hold results.

module arp_header_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_end,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_hw_type,
   output logic [15:0]      rsp_proto_kind,
   output logic [7:0]       rsp_hw_addr_len,
   output logic [7:0]       rsp_proto_addr_len,
   output logic [15:0]      rsp_op_code,
   output logic [47:0]      rsp_src_mac,
   output logic [31:0]      rsp_src_ip,
   output logic [47:0]      rsp_dst_mac,
   output logic [31:0]      rsp_dst_ip,
   output logic [10:0]      rsp_total_bytes
);

   logic                  accept;
   logic                  rec_push;
   arphp_pkg::record_type front_rec;
   logic                  q_valid, q_pop;
   arphp_pkg::record_type q_rec;
   logic                  out_valid;
   arphp_pkg::record_type out_rec;
   arphp_pkg::status_type out_status;

   assign accept = req_push && !req_full;

   arphp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .frame_end (req_frame_end),
      .rec_push  (rec_push),
      .rec       (front_rec)
   );

   arphp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (front_rec),
      .full     (req_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_rec  (q_rec)
   );

   arphp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rec      (q_rec),
      .q_pop      (q_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_rec    (out_rec),
      .out_status (out_status)
   );

   assign rsp_empty          = !out_valid;
   assign rsp_status         = out_status;
   assign rsp_hw_type        = out_rec.hw_type;
   assign rsp_proto_kind     = out_rec.proto_kind;
   assign rsp_hw_addr_len    = out_rec.hw_addr_len;
   assign rsp_proto_addr_len = out_rec.proto_addr_len;
   assign rsp_op_code        = out_rec.op_code;
   assign rsp_src_mac        = out_rec.src_mac;
   assign rsp_src_ip         = out_rec.src_ip;
   assign rsp_dst_mac        = out_rec.dst_mac;
   assign rsp_dst_ip         = out_rec.dst_ip;
   assign rsp_total_bytes    = out_rec.total_bytes;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("parser not idle after reset");

   a_short_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_total_bytes < 11'd28) |-> rsp_status == arphp_pkg::ST_TOO_SHORT)
      else $error("short packet without too-short status");

   a_ok_lengths: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == arphp_pkg::ST_OK) |->
         (rsp_hw_addr_len != 8'd0 && rsp_proto_addr_len != 8'd0))
      else $error("ok status with a zero address length");

endmodule

`default_nettype wire

// ===== tb/sv/arphp_check_pkg.sv =====
// Scoreboard for the ARP header parser testbench: predicts each packet record
// from the accepted bytes and checks the popped records in order.
// Depends on arphp_pkg for the record layout, status codes and header constants.
`timescale 1ns / 1ps

package arphp_check_pkg;

   import arphp_pkg::*;

   typedef struct packed {
      status_type status;
      record_type rec;
   } arp_result_type;

   class arp_record_checker;

      logic [7:0]         hdr_bytes [HDR_LEN];
      logic [COUNT_W-1:0] byte_total;
      arp_result_type     pending_records [$];
      int                 errors;

      function new();
         errors = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         byte_total = '0;
         foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
      endfunction

      // One accepted byte; on the last byte the packet record is queued.
      function void note_byte(logic [7:0] data_byte, logic frame_end);
         arp_result_type r;
         if (byte_total < HDR_LEN) hdr_bytes[byte_total] = data_byte;
         if (byte_total != COUNT_MAX) byte_total++;
         if (!frame_end) return;

         // header bytes that never arrived are still zero here
         r.rec.hw_type        = {hdr_bytes[0], hdr_bytes[1]};
         r.rec.proto_kind     = {hdr_bytes[2], hdr_bytes[3]};
         r.rec.hw_addr_len    = hdr_bytes[4];
         r.rec.proto_addr_len = hdr_bytes[5];
         r.rec.op_code        = {hdr_bytes[6], hdr_bytes[7]};
         r.rec.src_mac        = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10],
                                 hdr_bytes[11], hdr_bytes[12], hdr_bytes[13]};
         r.rec.src_ip         = {hdr_bytes[14], hdr_bytes[15], hdr_bytes[16],
                                 hdr_bytes[17]};
         r.rec.dst_mac        = {hdr_bytes[18], hdr_bytes[19], hdr_bytes[20],
                                 hdr_bytes[21], hdr_bytes[22], hdr_bytes[23]};
         r.rec.dst_ip         = {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26],
                                 hdr_bytes[27]};
         r.rec.total_bytes    = byte_total;

         if (byte_total < HDR_LEN) begin
            r.status = ST_TOO_SHORT;
         end else if (r.rec.hw_addr_len == 8'd0 || r.rec.proto_addr_len == 8'd0 ||
                      r.rec.op_code < OPCODE_MIN || r.rec.op_code > OPCODE_MAX ||
                      (r.rec.hw_type == HW_ETHERNET &&
                       r.rec.hw_addr_len != ETH_HW_LEN) ||
                      (r.rec.proto_kind == PROTO_IPV4 &&
                       r.rec.proto_addr_len != IPV4_PROTO_LEN)) begin
            r.status = ST_BAD_FORMAT;
         end else if (!(r.rec.hw_type inside {HW_ETHERNET, HW_IEEE802, HW_FRAME_RLY,
                                             HW_ATM}) ||
                      !(r.rec.proto_kind inside {PROTO_IPV4, PROTO_IPV6})) begin
            r.status = ST_UNSUPPORTED;
         end else begin
            r.status = ST_OK;
         end

         pending_records.push_back(r);
         clear_packet();
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_record(logic [1:0] status, record_type got);
         arp_result_type want;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, status %0d hw_type 'h%0h",
                     $time, status, got.hw_type);
            errors++;
            return;
         end
         want = pending_records.pop_front();
         compare("status", want.status, status);
         compare("hw_type", want.rec.hw_type, got.hw_type);
         compare("proto_kind", want.rec.proto_kind, got.proto_kind);
         compare("hw_addr_len", want.rec.hw_addr_len, got.hw_addr_len);
         compare("proto_addr_len", want.rec.proto_addr_len, got.proto_addr_len);
         compare("op_code", want.rec.op_code, got.op_code);
         compare("src_mac", want.rec.src_mac, got.src_mac);
         compare("src_ip", want.rec.src_ip, got.src_ip);
         compare("dst_mac", want.rec.dst_mac, got.dst_mac);
         compare("dst_ip", want.rec.dst_ip, got.dst_ip);
         compare("total_bytes", want.rec.total_bytes, got.total_bytes);
      endfunction

   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for arp_header_parser_top: drives packets byte by byte
// and pops records under varying idle and stall rates.
// Depends on arphp_pkg and arphp_check_pkg.
`timescale 1ns / 1ps

module tb_top;

   import arphp_pkg::*;
   import arphp_check_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum {
      FAULT_HW_LEN_ZERO,
      FAULT_PROTO_LEN_ZERO,
      FAULT_OPCODE,
      FAULT_ETH_LEN,
      FAULT_IPV4_LEN,
      FAULT_HW_TYPE,
      FAULT_PROTO_TYPE
   } fault_kind_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_frame_end;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_hw_type;
   logic [15:0] rsp_proto_kind;
   logic [7:0]  rsp_hw_addr_len;
   logic [7:0]  rsp_proto_addr_len;
   logic [15:0] rsp_op_code;
   logic [47:0] rsp_src_mac;
   logic [31:0] rsp_src_ip;
   logic [47:0] rsp_dst_mac;
   logic [31:0] rsp_dst_ip;
   logic [10:0] rsp_total_bytes;

   arp_record_checker rec_check = new();
   int                idle_pct  = 0;
   int                stall_pct = 0;
   int                cycles    = 0;
   logic [7:0]        frame_q [$];

   arp_header_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_frame_end      (req_frame_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_status         (rsp_status),
      .rsp_hw_type        (rsp_hw_type),
      .rsp_proto_kind     (rsp_proto_kind),
      .rsp_hw_addr_len    (rsp_hw_addr_len),
      .rsp_proto_addr_len (rsp_proto_addr_len),
      .rsp_op_code        (rsp_op_code),
      .rsp_src_mac        (rsp_src_mac),
      .rsp_src_ip         (rsp_src_ip),
      .rsp_dst_mac        (rsp_dst_mac),
      .rsp_dst_ip         (rsp_dst_ip),
      .rsp_total_bytes    (rsp_total_bytes)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Record side: check whatever was popped at this edge, then pick next pop.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            rec_check.check_record(rsp_status, record_type'{
               rsp_hw_type, rsp_proto_kind, rsp_hw_addr_len, rsp_proto_addr_len,
               rsp_op_code, rsp_src_mac, rsp_src_ip, rsp_dst_mac, rsp_dst_ip,
               rsp_total_bytes});
         rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data_byte, input logic frame_end);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= data_byte;
      req_frame_end <= frame_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      rec_check.note_byte(data_byte, frame_end);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   // Header is {hw, proto, hlen, plen, op, smac, sip, dmac, dip}, wire order.
   task automatic add_header(input logic [223:0] hdr);
      for (int i = 0; i < HDR_LEN; i++) frame_q.push_back(hdr[223 - 8 * i -: 8]);
   endtask

   task automatic add_random(input int count);
      repeat (count) frame_q.push_back(8'($urandom));
   endtask

   function automatic logic [223:0] good_header();
      logic [15:0] hw;
      logic [15:0] proto;
      logic [7:0]  hl;
      logic [7:0]  pl;
      case ($urandom_range(0, 3))
         0: hw = HW_ETHERNET;
         1: hw = HW_IEEE802;
         2: hw = HW_FRAME_RLY;
         default: hw = HW_ATM;
      endcase
      proto = $urandom_range(0, 1) ? PROTO_IPV6 : PROTO_IPV4;
      hl = (hw == HW_ETHERNET) ? ETH_HW_LEN : 8'($urandom_range(1, 255));
      pl = (proto == PROTO_IPV4) ? IPV4_PROTO_LEN : 8'($urandom_range(1, 255));
      return {hw, proto, hl, pl, 16'($urandom_range(OPCODE_MIN, OPCODE_MAX)),
              16'($urandom), 32'($urandom), 32'($urandom),
              16'($urandom), 32'($urandom), 32'($urandom)};
   endfunction

   initial begin
      logic [223:0] hdr;
      logic [7:0]   len_byte;
      int           sent;
      int           pick;
      int           keep;
      int           idle_by_phase [4]  = '{0, 55, 0, 14};
      int           stall_by_phase [4] = '{0, 0, 55, 14};

      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = 8'h00;
      req_frame_end = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // one-byte packets with all-ones and all-zeros data
      frame_q.push_back(8'hFF);
      send_frame();
      frame_q.push_back(8'h00);
      send_frame();
      // minimal valid Ethernet/IPv4 request with extreme addresses
      add_header({HW_ETHERNET, PROTO_IPV4, ETH_HW_LEN, IPV4_PROTO_LEN, OPCODE_MIN,
                  48'hFFFF_FFFF_FFFF, 32'h0, 48'h0, 32'hFFFF_FFFF});
      send_frame();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         sent = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               hdr = good_header();
               if ($urandom_range(0, 1)) begin
                  case (fault_kind_type'($urandom_range(FAULT_HW_LEN_ZERO,
                                                        FAULT_PROTO_TYPE)))
                     FAULT_HW_LEN_ZERO:    hdr[191:184] = 8'd0;
                     FAULT_PROTO_LEN_ZERO: hdr[183:176] = 8'd0;
                     FAULT_OPCODE:
                        hdr[175:160] = $urandom_range(0, 1) ? 16'd0 :
                                       16'($urandom_range(OPCODE_MAX + 1, 16'hFFFF));
                     FAULT_ETH_LEN: begin
                        len_byte = 8'($urandom_range(0, 254));
                        if (len_byte >= ETH_HW_LEN) len_byte++;
                        hdr[223:208] = HW_ETHERNET;
                        hdr[191:184] = len_byte;
                     end
                     FAULT_IPV4_LEN: begin
                        len_byte = 8'($urandom_range(0, 254));
                        if (len_byte >= IPV4_PROTO_LEN) len_byte++;
                        hdr[207:192] = PROTO_IPV4;
                        hdr[183:176] = len_byte;
                     end
                     FAULT_HW_TYPE:        hdr[223:208] = 16'($urandom);
                     default:              hdr[207:192] = 16'($urandom);
                  endcase
               end
               add_header(hdr);
               if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 30));
            end else if (pick < 75) begin
               // truncated packet: a good header prefix or plain noise
               keep = $urandom_range(1, HDR_LEN - 1);
               if ($urandom_range(0, 1)) add_header(good_header());
               else add_random(keep);
               while (frame_q.size() > keep) void'(frame_q.pop_back());
            end else if (pick < 90) begin
               add_random($urandom_range(HDR_LEN, HDR_LEN + 12));
            end else begin
               add_header({16'($urandom), 16'($urandom), 32'($urandom),
                           16'($urandom), 32'($urandom), 32'($urandom),
                           16'($urandom), 32'($urandom), 32'($urandom)});
               add_random($urandom_range(0, 4));
            end
            sent += frame_q.size();
            send_frame();
         end
      end

      req_push <= 1'b0;
      while (rec_check.pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rec_check.errors == 0 && rec_check.pending_records.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/arphp_pkg.sv
rtl/core/arphp_front.sv
rtl/core/arphp_fifo.sv
rtl/core/arphp_back.sv
rtl/core/arp_header_parser_top.sv
tb/sv/arphp_check_pkg.sv
tb/sv/tb_top.sv
